// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rnf_pkg.sv =====
// ----------------------------------------------------------------------------
// rnf_pkg
// Types and constants shared by the RTP NAL fragmenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rnf_pkg;

	// configuration port
	localparam int CFG_DATA_BITS = 14;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PACKET = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCHEME = 1'd1;
	localparam logic [CFG_DATA_BITS-1:0] MAX_PACKET_RESET = 14'd1400;

	localparam logic [1:0] SCHEME_H264 = 2'd0;
	localparam logic [1:0] SCHEME_H265 = 2'd1;

	// prefix layout
	localparam logic [1:0] HDR_LEN_NONE = 2'd0;
	localparam logic [1:0] HDR_LEN_FUA = 2'd2;
	localparam logic [1:0] HDR_LEN_H265 = 2'd3;
	localparam logic [4:0] FUA_TYPE = 5'd28;
	localparam logic [5:0] H265_FU_TYPE = 6'd49;
	localparam logic [7:0] NRI_MASK = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1F;
	localparam logic [7:0] H265_HDR0 = {1'b0, H265_FU_TYPE, 1'b0};
	localparam logic [7:0] H265_HDR1 = 8'h01;

	localparam int CMD_FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_SINGLE,
		KIND_ERROR,
		KIND_FRAG
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_COUNT,
		ST_DIV_SIZE,
		ST_EMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/rnf_divider.sv =====
// ----------------------------------------------------------------------------
// rnf_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_divider #(
	parameter int N = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [N-1:0] dividend,
	input  wire logic [N:0]   divisor,
	output logic              done,
	output logic [N-1:0]      quotient
);

	localparam int CNT_BITS = $clog2(N + 1);

	logic [N-1:0]        rem_q;
	logic [N-1:0]        quo_q;
	logic [N:0]          dsr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [N:0]          trial;
	logic                fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign fits = trial >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the difference fits N bits
			rem_q <= fits ? N'(trial - dsr_q) : trial[N-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/rnf_front.sv =====
// ----------------------------------------------------------------------------
// rnf_front
// Configuration registers and classification of incoming NAL descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_front #(
	parameter int SIZE_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rnf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [rnf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic [15:0]                        nal_size,
	input  wire logic [7:0]                         nal_header_first,
	output rnf_pkg::cmd_kind_t                      kind,
	output logic                                    h265,
	output logic [SIZE_BITS-1:0]                    size,
	output logic [SIZE_BITS-1:0]                    payload,
	output logic [rnf_pkg::CFG_DATA_BITS-1:0]       cap,
	output logic [7:0]                              header
);

	localparam int CW = SIZE_BITS + rnf_pkg::CFG_DATA_BITS;

	logic [rnf_pkg::CFG_DATA_BITS-1:0] max_packet_q;
	logic [1:0]                        scheme_q;
	logic [SIZE_BITS-1:0]              hdr_len;
	logic [rnf_pkg::CFG_DATA_BITS-1:0] fu_len;
	logic                              too_big;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packet_q <= rnf_pkg::MAX_PACKET_RESET;
			scheme_q <= rnf_pkg::SCHEME_H264;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rnf_pkg::REG_MAX_PACKET: max_packet_q <= cfg_data;
				rnf_pkg::REG_SCHEME: scheme_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign size = SIZE_BITS'(nal_size);
	assign header = nal_header_first;
	assign h265 = scheme_q == rnf_pkg::SCHEME_H265;
	assign hdr_len = h265 ? SIZE_BITS'(2) : SIZE_BITS'(1);
	assign fu_len = h265 ? rnf_pkg::CFG_DATA_BITS'(3) : rnf_pkg::CFG_DATA_BITS'(2);
	assign too_big = CW'(size) > CW'(max_packet_q);

	// fragment limit never drops below one byte
	assign cap = (max_packet_q > fu_len) ? max_packet_q - fu_len
		: rnf_pkg::CFG_DATA_BITS'(1);
	assign payload = (size > hdr_len) ? size - hdr_len : '0;

	always_comb begin
		if (!too_big) begin
			kind = rnf_pkg::KIND_SINGLE;
		end else if (scheme_q != rnf_pkg::SCHEME_H264 && scheme_q != rnf_pkg::SCHEME_H265) begin
			kind = rnf_pkg::KIND_ERROR;
		end else begin
			kind = rnf_pkg::KIND_FRAG;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rnf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rnf_cmd_fifo
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_cmd_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  not_empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full = count_q == CNT_BITS'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rnf_back.sv =====
// ----------------------------------------------------------------------------
// rnf_back
// Runs the two size divisions and sequences the packets of one NAL unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_back #(
	parameter int SIZE_BITS = 16,
	parameter int MAX_FRAGMENTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_pop,
	input  wire rnf_pkg::cmd_kind_t                cmd_kind,
	input  wire logic                              cmd_h265,
	input  wire logic [SIZE_BITS-1:0]              cmd_size,
	input  wire logic [SIZE_BITS-1:0]              cmd_payload,
	input  wire logic [rnf_pkg::CFG_DATA_BITS-1:0] cmd_cap,
	input  wire logic [7:0]                        cmd_header,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [15:0]                            payload_offset,
	output logic [15:0]                            payload_length,
	output logic [1:0]                             header_length,
	output logic [7:0]                             header_byte0,
	output logic [7:0]                             header_byte1,
	output logic [7:0]                             header_byte2,
	output logic                                   last,
	output logic                                   error
);

	localparam int CW = SIZE_BITS + rnf_pkg::CFG_DATA_BITS;
	localparam int CNT_BITS = $clog2(MAX_FRAGMENTS);

	rnf_pkg::back_state_t state_q, state_d;

	logic                              div_start;
	logic [SIZE_BITS-1:0]              div_dividend;
	logic [SIZE_BITS:0]                div_divisor;
	logic                              div_done;
	logic [SIZE_BITS-1:0]              div_quotient;

	logic                              h265_q;
	logic [7:0]                        header_q;
	logic [SIZE_BITS-1:0]              payload_q;
	logic [rnf_pkg::CFG_DATA_BITS-1:0] cap_q;
	logic [SIZE_BITS-1:0]              frag_len_q;
	logic [SIZE_BITS-1:0]              rem_q;
	logic [SIZE_BITS-1:0]              offset_q;
	logic [CNT_BITS-1:0]               frag_cnt_q;

	logic                              out_valid_q;
	logic [15:0]                       offset_out_q;
	logic [15:0]                       length_out_q;
	logic [1:0]                        hlen_out_q;
	logic [7:0]                        byte0_out_q;
	logic [7:0]                        byte1_out_q;
	logic [7:0]                        byte2_out_q;
	logic                              last_out_q;
	logic                              error_out_q;

	logic                              out_free;
	logic                              load;
	logic                              take_cmd;
	logic                              init_emit;
	logic                              step;
	logic                              end_frag;
	logic [SIZE_BITS-1:0]              len;
	logic [1:0]                        se;
	logic [15:0]                       ld_offset;
	logic [15:0]                       ld_length;
	logic [1:0]                        ld_hlen;
	logic [7:0]                        ld_byte0;
	logic [7:0]                        ld_byte1;
	logic [7:0]                        ld_byte2;
	logic                              ld_last;
	logic                              ld_error;

	rnf_divider #(
		.N(SIZE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quotient)
	);

	assign out_free = !out_valid_q || !out_stall;

	// the final fragment takes the rest once it fits, or when the count runs out
	assign end_frag = (CW'(rem_q) <= CW'(cap_q))
		|| (frag_cnt_q == CNT_BITS'(MAX_FRAGMENTS - 1));
	assign len = end_frag ? rem_q : frag_len_q;
	assign se = {frag_cnt_q == '0, end_frag};

	assign div_dividend = (state_q == rnf_pkg::ST_IDLE) ? cmd_payload : payload_q;
	assign div_divisor = (state_q == rnf_pkg::ST_IDLE) ? (SIZE_BITS + 1)'(cmd_cap)
		: (SIZE_BITS + 1)'(div_quotient) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rnf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		div_start = 1'b0;
		load = 1'b0;
		take_cmd = 1'b0;
		init_emit = 1'b0;
		step = 1'b0;
		ld_offset = '0;
		ld_length = '0;
		ld_hlen = rnf_pkg::HDR_LEN_NONE;
		ld_byte0 = '0;
		ld_byte1 = '0;
		ld_byte2 = '0;
		ld_last = 1'b1;
		ld_error = 1'b0;
		unique case (state_q)
			rnf_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd_kind)
						rnf_pkg::KIND_SINGLE: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								load = 1'b1;
								ld_length = 16'(cmd_size);
							end
						end
						rnf_pkg::KIND_FRAG: begin
							cmd_pop = 1'b1;
							take_cmd = 1'b1;
							div_start = 1'b1;
							state_d = rnf_pkg::ST_DIV_COUNT;
						end
						default: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								load = 1'b1;
								ld_error = 1'b1;
							end
						end
					endcase
				end
			end
			rnf_pkg::ST_DIV_COUNT: begin
				// fragment count known: divide again for the fragment size
				if (div_done) begin
					div_start = 1'b1;
					state_d = rnf_pkg::ST_DIV_SIZE;
				end
			end
			rnf_pkg::ST_DIV_SIZE: begin
				if (div_done) begin
					init_emit = 1'b1;
					state_d = rnf_pkg::ST_EMIT;
				end
			end
			rnf_pkg::ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					step = 1'b1;
					ld_offset = 16'(offset_q);
					ld_length = 16'(len);
					ld_last = end_frag;
					if (h265_q) begin
						ld_hlen = rnf_pkg::HDR_LEN_H265;
						ld_byte0 = rnf_pkg::H265_HDR0;
						ld_byte1 = rnf_pkg::H265_HDR1;
						ld_byte2 = {se, header_q[6:1]};
					end else begin
						ld_hlen = rnf_pkg::HDR_LEN_FUA;
						ld_byte0 = (header_q & rnf_pkg::NRI_MASK) | {3'b000, rnf_pkg::FUA_TYPE};
						ld_byte1 = {se, 6'b0} | (header_q & rnf_pkg::TYPE_MASK);
					end
					if (end_frag) begin
						state_d = rnf_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = rnf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			h265_q <= cmd_h265;
			header_q <= cmd_header;
			payload_q <= cmd_payload;
			cap_q <= cmd_cap;
		end
		if (init_emit) begin
			frag_len_q <= (div_quotient == '0) ? SIZE_BITS'(1) : div_quotient;
			rem_q <= payload_q;
			offset_q <= h265_q ? SIZE_BITS'(2) : SIZE_BITS'(1);
			frag_cnt_q <= '0;
		end else if (step) begin
			rem_q <= rem_q - len;
			offset_q <= offset_q + len;
			frag_cnt_q <= frag_cnt_q + 1'b1;
		end
		if (load) begin
			offset_out_q <= ld_offset;
			length_out_q <= ld_length;
			hlen_out_q <= ld_hlen;
			byte0_out_q <= ld_byte0;
			byte1_out_q <= ld_byte1;
			byte2_out_q <= ld_byte2;
			last_out_q <= ld_last;
			error_out_q <= ld_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_offset = offset_out_q;
	assign payload_length = length_out_q;
	assign header_length = hlen_out_q;
	assign header_byte0 = byte0_out_q;
	assign header_byte1 = byte1_out_q;
	assign header_byte2 = byte2_out_q;
	assign last = last_out_q;
	assign error = error_out_q;

endmodule

`default_nettype wire

// ===== rtl/rtp_nal_fragmenter.sv =====
// ----------------------------------------------------------------------------
// rtp_nal_fragmenter
// Splits NAL unit descriptors into RTP packet descriptors (FU-A / H.265 FU).
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with nal_size and nal_header_first; a
// transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall, one transfer per RTP packet.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// max_packet_bytes (0) or scheme (1); write only while the block is idle.
// A two-entry command queue sits between the classifier and the packet
// sequencer, so new units are taken while packets are still going out.
// An unfragmented or error unit passes through the command queue and the
// output register to reach the output. A fragmented unit runs two serial
// divisions in the shared divider, then emits one fragment per cycle while
// out_stall is low.
// Reset sets max_packet_bytes to 1400 and scheme to H.264 and empties the
// queue. While out_stall is high the packet on the output holds; the queue
// keeps taking units until it is full, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_nal_fragmenter #(
	parameter int NAL_SIZE_BITS = 16,
	parameter int MAX_FRAGMENTS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rnf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [rnf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [15:0]                        nal_size,
	input  wire logic [7:0]                         nal_header_first,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [15:0]                             payload_offset,
	output logic [15:0]                             payload_length,
	output logic [1:0]                              header_length,
	output logic [7:0]                              header_byte0,
	output logic [7:0]                              header_byte1,
	output logic [7:0]                              header_byte2,
	output logic                                    last,
	output logic                                    error
);

	localparam int SW = NAL_SIZE_BITS;
	localparam int CAPW = rnf_pkg::CFG_DATA_BITS;
	localparam int CMD_W = 2 + 1 + SW + SW + CAPW + 8;

	rnf_pkg::cmd_kind_t f_kind;
	logic               f_h265;
	logic [SW-1:0]      f_size;
	logic [SW-1:0]      f_payload;
	logic [CAPW-1:0]    f_cap;
	logic [7:0]         f_header;

	logic               push;
	logic               pop;
	logic               fifo_full;
	logic               fifo_not_empty;
	logic [CMD_W-1:0]   wr_data;
	logic [CMD_W-1:0]   rd_data;

	rnf_pkg::cmd_kind_t b_kind;
	logic               b_h265;
	logic [SW-1:0]      b_size;
	logic [SW-1:0]      b_payload;
	logic [CAPW-1:0]    b_cap;
	logic [7:0]         b_header;

	rnf_front #(
		.SIZE_BITS(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.nal_size(nal_size),
		.nal_header_first(nal_header_first),
		.kind(f_kind),
		.h265(f_h265),
		.size(f_size),
		.payload(f_payload),
		.cap(f_cap),
		.header(f_header)
	);

	assign in_stall = fifo_full;
	assign push = in_valid && !fifo_full;
	assign wr_data = {f_kind, f_h265, f_size, f_payload, f_cap, f_header};

	rnf_cmd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(rnf_pkg::CMD_FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(wr_data),
		.pop(pop),
		.rd_data(rd_data),
		.full(fifo_full),
		.not_empty(fifo_not_empty)
	);

	assign b_kind = rnf_pkg::cmd_kind_t'(rd_data[CMD_W-1 -: 2]);
	assign {b_h265, b_size, b_payload, b_cap, b_header} = rd_data[CMD_W-3:0];

	rnf_back #(
		.SIZE_BITS(SW),
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(fifo_not_empty),
		.cmd_pop(pop),
		.cmd_kind(b_kind),
		.cmd_h265(b_h265),
		.cmd_size(b_size),
		.cmd_payload(b_payload),
		.cmd_cap(b_cap),
		.cmd_header(b_header),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.header_length(header_length),
		.header_byte0(header_byte0),
		.header_byte1(header_byte1),
		.header_byte2(header_byte2),
		.last(last),
		.error(error)
	);

endmodule

`default_nettype wire

// ===== rtl/rnf_checker.sv =====
// ----------------------------------------------------------------------------
// rnf_checker
// Port-level checks on the fragmenter output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rnf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] payload_offset,
	input wire logic [15:0] payload_length,
	input wire logic [1:0]  header_length,
	input wire logic [7:0]  header_byte0,
	input wire logic [7:0]  header_byte1,
	input wire logic [7:0]  header_byte2,
	input wire logic        last,
	input wire logic        error
);

	// a stalled packet holds its place
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(payload_offset) && $stable(payload_length) && $stable(last))

	// an error packet is a lone empty packet
	`ASSERT_HOLDS(a_error_shape, clk, arst_n, out_valid && error,
		last && payload_length == 16'd0 && header_length == rnf_pkg::HDR_LEN_NONE)

	// FU-A end bit follows the last flag
	`ASSERT_HOLDS(a_fua_end, clk, arst_n, out_valid && header_length == rnf_pkg::HDR_LEN_FUA,
		header_byte1[6] == last && header_byte2 == 8'd0 && !error)

	// H.265 FU end bit follows the last flag
	`ASSERT_HOLDS(a_h265_end, clk, arst_n, out_valid && header_length == rnf_pkg::HDR_LEN_H265,
		header_byte2[6] == last && header_byte0 == rnf_pkg::H265_HDR0 && !error)

endmodule

bind rtp_nal_fragmenter rnf_checker u_rnf_checker (.*);

`default_nettype wire
